// ----- hw/rtl/sfht_pkg.sv -----
// Shared constants, types and hash functions of the split frequency hash table.
`default_nettype none
package sfht_pkg;

   localparam int MAX_WORDS   = 8;
   localparam int WIDX_W      = 3;
   localparam int POS_W       = 4;
   localparam int MAX_ENTRIES = 1024;
   localparam int ENT_W       = 10;
   localparam int LINK_W      = 11;
   localparam int BKT_W       = 10;
   localparam int WADDR_W     = ENT_W + WIDX_W;

   localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(MAX_ENTRIES);
   localparam logic [3:0]        TSL_MIN  = 4'd6;
   localparam logic [3:0]        TSL_MAX  = 4'd10;

   localparam logic [1:0] STATUS_ADDED     = 2'd0;
   localparam logic [1:0] STATUS_INSERTED  = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   localparam logic [7:0] CSR_TABLE_SIZE_LOG2 = 8'd0;
   localparam logic [7:0] CSR_SPLIT_WORDS     = 8'd1;

   typedef enum logic [11:0] {
      ST_CLEAR    = 12'b0000_0000_0001,
      ST_IDLE     = 12'b0000_0000_0010,
      ST_PAD      = 12'b0000_0000_0100,
      ST_FINISH   = 12'b0000_0000_1000,
      ST_HEAD_RD  = 12'b0000_0001_0000,
      ST_HEAD_CHK = 12'b0000_0010_0000,
      ST_ENT_RD   = 12'b0000_0100_0000,
      ST_ENT_CHK  = 12'b0000_1000_0000,
      ST_WORD_RD  = 12'b0001_0000_0000,
      ST_WORD_CHK = 12'b0010_0000_0000,
      ST_DECIDE   = 12'b0100_0000_0000,
      ST_INS_WR   = 12'b1000_0000_0000
   } state_type;

   typedef struct packed {
      logic fold;
      logic clear;
   } hsh_ctl_type;

   typedef struct packed {
      logic               head_re;
      logic [BKT_W-1:0]   head_raddr;
      logic               head_we;
      logic [BKT_W-1:0]   head_waddr;
      logic [LINK_W-1:0]  head_wdata;
      logic               ent_re;
      logic [ENT_W-1:0]   ent_raddr;
      logic               ent_we;
      logic               wgt_we;
      logic [ENT_W-1:0]   ent_waddr;
      logic [31:0]        key_wdata;
      logic [LINK_W-1:0]  link_wdata;
      logic [31:0]        wgt_wdata;
      logic [15:0]        bip_wdata;
      logic               word_re;
      logic [WADDR_W-1:0] word_raddr;
      logic               word_we;
      logic [WADDR_W-1:0] word_waddr;
      logic [31:0]        word_wdata;
   } mem_req_type;

   typedef struct packed {
      logic [LINK_W-1:0] head_q;
      logic [31:0]       key_q;
      logic [LINK_W-1:0] link_q;
      logic [31:0]       wgt_q;
      logic [31:0]       word_q;
   } mem_rsp_type;

   function automatic logic [31:0] fold_word(input logic [31:0] h, input logic [31:0] w);
      logic [31:0] t;
      t = h + w;
      t = t + (t << 10);
      t = t ^ (t >> 6);
      return t;
   endfunction

   function automatic logic [31:0] finish_hash(input logic [31:0] h);
      logic [31:0] t;
      t = h + (h << 3);
      t = t ^ (t >> 11);
      t = t + (t << 15);
      return t;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sfht_hasher.sv -----
// Running hash, word position and buffered words of the split being received.
`default_nettype none
module sfht_hasher
   import sfht_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire hsh_ctl_type       ctl,
   input  wire logic [31:0]       word,
   input  wire logic [WIDX_W-1:0] rd_idx,
   output logic [31:0]            rd_word,
   output logic [31:0]            hash,
   output logic [POS_W-1:0]       pos
);

   logic [31:0]      words_ff [MAX_WORDS];
   logic [31:0]      hash_ff, hash_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   always_comb begin
      hash_in = hash_ff;
      pos_in  = pos_ff;
      if (ctl.clear) begin
         hash_in = '0;
         pos_in  = '0;
      end else if (ctl.fold) begin
         hash_in = fold_word(hash_ff, word);
         pos_in  = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
         pos_ff  <= '0;
      end else begin
         hash_ff <= hash_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fold && !ctl.clear) begin
         words_ff[pos_ff[WIDX_W-1:0]] <= word;
      end
   end

   assign rd_word = words_ff[rd_idx];
   assign hash    = hash_ff;
   assign pos     = pos_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/sfht_store.sv -----
// Bucket head and entry memories with registered read data.
`default_nettype none
module sfht_store
   import sfht_pkg::*;
(
   input  wire logic        clock,
   input  wire mem_req_type req,
   output mem_rsp_type      rsp
);

   logic [LINK_W-1:0] head_mem [2**BKT_W];
   logic [31:0]       key_mem  [MAX_ENTRIES];
   logic [LINK_W-1:0] link_mem [MAX_ENTRIES];
   logic [31:0]       wgt_mem  [MAX_ENTRIES];
   logic [15:0]       bip_mem  [MAX_ENTRIES];
   logic [31:0]       word_mem [MAX_ENTRIES * MAX_WORDS];

   always_ff @(posedge clock) begin
      if (req.head_we) begin
         head_mem[req.head_waddr] <= req.head_wdata;
      end
      if (req.head_re) begin
         rsp.head_q <= head_mem[req.head_raddr];
      end
      if (req.ent_we) begin
         key_mem[req.ent_waddr]  <= req.key_wdata;
         link_mem[req.ent_waddr] <= req.link_wdata;
         bip_mem[req.ent_waddr]  <= req.bip_wdata;
      end
      if (req.wgt_we) begin
         wgt_mem[req.ent_waddr] <= req.wgt_wdata;
      end
      if (req.ent_re) begin
         rsp.key_q  <= key_mem[req.ent_raddr];
         rsp.link_q <= link_mem[req.ent_raddr];
         rsp.wgt_q  <= wgt_mem[req.ent_raddr];
      end
      if (req.word_we) begin
         word_mem[req.word_waddr] <= req.word_wdata;
      end
      if (req.word_re) begin
         rsp.word_q <= word_mem[req.word_raddr];
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/split_frequency_hash_table_core.sv -----
// Top level of the split frequency hash table: control sequencer and ports.
//
// Each item on the req_ channel carries one 32-bit word of a split bit vector.
// Words are taken one per cycle while the block is idle; those within the configured
// split length are folded into a running hash. The item with req_tlast set ends the
// split; the block then finalizes the key, reads the bucket head and walks the chain,
// and returns one item on the rsp_ channel with the status, the entry slot, its
// support and the entry count.
// Missing words are padded with zeros before the key is finalized. The chain walk
// reads one entry at a time; on a key match the stored words are compared one by
// one, and a new entry is inserted with 8 word writes.
// After reset the 1024 bucket heads are cleared in a pass during which req_tready
// is low; configuration writes are taken at any time.
// The result sits in an output register; a stalled receiver holds it while the
// next split streams in, and the block waits before a second result only.
`default_nettype none
module split_frequency_hash_table_core
   import sfht_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,  // split_word, support, bipartition id
   input  wire logic        req_tuser,  // operation
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,  // entry_index, entry_support, entry_total, zero fill
   output logic [1:0]       rsp_tuser,  // status
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   state_type         state_ff, state_in;
   logic [3:0]        tsl_ff, words_cfg_ff;
   logic [BKT_W-1:0]  clr_ff, clr_in;
   logic [31:0]       key_ff, key_in;
   logic [BKT_W-1:0]  bucket_ff, bucket_in;
   logic [LINK_W-1:0] head_ff, head_in, e_ff, e_in, link_ff, link_in;
   logic [WIDX_W-1:0] i_ff, i_in;
   logic              found_ff, found_in, op_ff, op_in;
   logic [31:0]       sup_ff, sup_in;
   logic [15:0]       bip_ff, bip_in;
   logic [LINK_W-1:0] used_ff, used_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [ENT_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [31:0]       rsp_sup_ff, rsp_sup_in;
   logic [LINK_W-1:0] rsp_total_ff, rsp_total_in;

   hsh_ctl_type       hctl;
   logic [31:0]       hword, rd_word, hash;
   logic [POS_W-1:0]  pos;
   mem_req_type       mreq;
   mem_rsp_type       mrsp;

   logic [POS_W-1:0]  len;
   logic [3:0]        lg;
   logic [BKT_W:0]    pow;
   logic [BKT_W-1:0]  mask;
   logic [32:0]       sum;
   logic [31:0]       sat;
   logic              accept, slot_free;

   sfht_hasher u_hasher (
      .clock   (clock),
      .reset   (reset),
      .ctl     (hctl),
      .word    (hword),
      .rd_idx  (i_ff),
      .rd_word (rd_word),
      .hash    (hash),
      .pos     (pos)
   );

   sfht_store u_store (
      .clock (clock),
      .req   (mreq),
      .rsp   (mrsp)
   );

   always_comb begin
      len = words_cfg_ff;
      if (words_cfg_ff == '0) begin
         len = POS_W'(1);
      end else if (words_cfg_ff > POS_W'(MAX_WORDS)) begin
         len = POS_W'(MAX_WORDS);
      end
      lg = tsl_ff;
      if (tsl_ff < TSL_MIN) begin
         lg = TSL_MIN;
      end else if (tsl_ff > TSL_MAX) begin
         lg = TSL_MAX;
      end
      pow  = (BKT_W + 1)'(1) << lg;
      mask = BKT_W'(pow - 1'b1);
      sum  = {1'b0, mrsp.wgt_q} + {1'b0, sup_ff};
      sat  = sum[32] ? '1 : sum[31:0];
   end

   assign accept    = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign hword     = (state_ff == ST_IDLE) ? req_tdata[31:0] : '0;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      key_in        = key_ff;
      bucket_in     = bucket_ff;
      head_in       = head_ff;
      e_in          = e_ff;
      link_in       = link_ff;
      i_in          = i_ff;
      found_in      = found_ff;
      op_in         = op_ff;
      sup_in        = sup_ff;
      bip_in        = bip_ff;
      used_in       = used_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_sup_in    = rsp_sup_ff;
      rsp_total_in  = rsp_total_ff;
      hctl          = '0;
      mreq          = '0;
      req_tready    = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_CLEAR: begin
            mreq.head_we    = 1'b1;
            mreq.head_waddr = clr_ff;
            mreq.head_wdata = NIL_LINK;
            clr_in          = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               hctl.fold = (pos < len);
               if (req_tlast) begin
                  op_in    = req_tuser;
                  sup_in   = req_tdata[63:32];
                  bip_in   = req_tdata[79:64];
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (pos < len) begin
               hctl.fold = 1'b1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            key_in     = finish_hash(hash);
            hctl.clear = 1'b1;
            found_in   = 1'b0;
            state_in   = ST_HEAD_RD;
         end
         ST_HEAD_RD: begin
            bucket_in       = key_ff[BKT_W-1:0] & mask;
            mreq.head_re    = 1'b1;
            mreq.head_raddr = key_ff[BKT_W-1:0] & mask;
            state_in        = ST_HEAD_CHK;
         end
         ST_HEAD_CHK: begin
            head_in  = mrsp.head_q;
            e_in     = mrsp.head_q;
            state_in = (mrsp.head_q == NIL_LINK) ? ST_DECIDE : ST_ENT_RD;
         end
         ST_ENT_RD: begin
            mreq.ent_re    = 1'b1;
            mreq.ent_raddr = e_ff[ENT_W-1:0];
            state_in       = ST_ENT_CHK;
         end
         ST_ENT_CHK: begin
            link_in = mrsp.link_q;
            if (mrsp.key_q == key_ff) begin
               i_in     = '0;
               state_in = ST_WORD_RD;
            end else begin
               e_in     = mrsp.link_q;
               state_in = (mrsp.link_q == NIL_LINK) ? ST_DECIDE : ST_ENT_RD;
            end
         end
         ST_WORD_RD: begin
            mreq.word_re    = 1'b1;
            mreq.word_raddr = {e_ff[ENT_W-1:0], i_ff};
            state_in        = ST_WORD_CHK;
         end
         ST_WORD_CHK: begin
            if (mrsp.word_q != rd_word) begin
               e_in     = link_ff;
               state_in = (link_ff == NIL_LINK) ? ST_DECIDE : ST_ENT_RD;
            end else if ({1'b0, i_ff} == len - 1'b1) begin
               found_in = 1'b1;
               state_in = ST_DECIDE;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_WORD_RD;
            end
         end
         ST_DECIDE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               rsp_index_in = '0;
               rsp_sup_in   = '0;
               rsp_total_in = used_ff;
               if (found_ff) begin
                  mreq.wgt_we    = 1'b1;
                  mreq.ent_waddr = e_ff[ENT_W-1:0];
                  mreq.wgt_wdata = sat;
                  rsp_status_in  = STATUS_ADDED;
                  rsp_index_in   = e_ff[ENT_W-1:0];
                  rsp_sup_in     = sat;
               end else if (op_ff) begin
                  rsp_status_in = STATUS_NOT_FOUND;
               end else if (used_ff == LINK_W'(MAX_ENTRIES)) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  mreq.ent_we     = 1'b1;
                  mreq.wgt_we     = 1'b1;
                  mreq.ent_waddr  = used_ff[ENT_W-1:0];
                  mreq.key_wdata  = key_ff;
                  mreq.link_wdata = head_ff;
                  mreq.wgt_wdata  = sup_ff;
                  mreq.bip_wdata  = bip_ff;
                  mreq.head_we    = 1'b1;
                  mreq.head_waddr = bucket_ff;
                  mreq.head_wdata = used_ff;
                  used_in         = used_ff + 1'b1;
                  e_in            = used_ff;
                  i_in            = '0;
                  rsp_status_in   = STATUS_INSERTED;
                  rsp_index_in    = used_ff[ENT_W-1:0];
                  rsp_sup_in      = sup_ff;
                  rsp_total_in    = used_ff + 1'b1;
                  state_in        = ST_INS_WR;
               end
            end
         end
         ST_INS_WR: begin
            mreq.word_we    = 1'b1;
            mreq.word_waddr = {e_ff[ENT_W-1:0], i_ff};
            mreq.word_wdata = ({1'b0, i_ff} < len) ? rd_word : '0;
            i_in            = i_ff + 1'b1;
            if (i_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         tsl_ff       <= 4'd10;
         words_cfg_ff <= 4'd1;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_TABLE_SIZE_LOG2: tsl_ff       <= csr_data[3:0];
               CSR_SPLIT_WORDS:     words_cfg_ff <= csr_data[3:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      bucket_ff     <= bucket_in;
      head_ff       <= head_in;
      e_ff          <= e_in;
      link_ff       <= link_in;
      i_ff          <= i_in;
      found_ff      <= found_in;
      op_ff         <= op_in;
      sup_ff        <= sup_in;
      bip_ff        <= bip_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_sup_ff    <= rsp_sup_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_total_ff, rsp_sup_ff, rsp_index_ff};

endmodule
`default_nettype wire

// ----- tb/tb_split_frequency_hash_table_core.sv -----
// Self-checking testbench of the split frequency hash table core with its own predictor.
`default_nettype none
module tb_split_frequency_hash_table_core
   import sfht_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCH_LIMIT = 20000;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      bit        op;
      bit [31:0] word;
      bit        last;
      bit [31:0] sup;
      bit [15:0] bip;
   } split_item_type;

   typedef struct {
      bit [1:0]  status;
      bit [9:0]  idx;
      bit [31:0] sup;
      bit [10:0] total;
   } lookup_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;  // split_word, support, bipartition id
   logic        req_tuser = 1'b0;  // operation
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;  // entry_index, entry_support, entry_total, zero fill
   logic [1:0]  rsp_tuser;  // status
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   split_item_type    pending_words[$];
   lookup_result_type expected_lookups[$];
   bit [31:0]         vector_pool[$][8];

   bit [3:0]  cfg_tsl = 4'd10;
   bit [3:0]  cfg_sw = 4'd1;
   bit [10:0] head_tbl[1024];
   bit [31:0] key_tbl[1024];
   bit [31:0] words_tbl[8192];
   bit [31:0] weight_tbl[1024];
   bit [10:0] link_tbl[1024];
   bit [10:0] used_count = '0;
   bit [31:0] split_buf[8];
   bit [31:0] hash_acc = '0;
   int        word_pos = 0;

   split_item_type cur_item;
   bit             idle_on = 1'b1;
   bit             hold_trigger = 1'b0;
   bit             hold_done = 1'b0;
   int             hold_count = 0;
   int             send_gap = 0;
   int             recv_gap = 0;
   int             fail_count = 0;
   int             quiet_cycles = 0;

   split_frequency_hash_table_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   function automatic bit [31:0] mix_word(bit [31:0] h, bit [31:0] w);
      bit [31:0] t;
      t = h + w;
      t = t + {t[21:0], 10'b0};
      t = t ^ {6'b0, t[31:6]};
      return t;
   endfunction

   function automatic bit [31:0] close_hash(bit [31:0] h);
      bit [31:0] t;
      t = h + {h[28:0], 3'b0};
      t = t ^ {11'b0, t[31:11]};
      t = t + {t[16:0], 15'b0};
      return t;
   endfunction

   function automatic int active_words();
      if (cfg_sw < 1) return 1;
      if (cfg_sw > MAX_WORDS) return MAX_WORDS;
      return cfg_sw;
   endfunction

   function automatic bit predict_lookup(input split_item_type it, output lookup_result_type r);
      int        len;
      int        lg;
      int        e;
      int        steps;
      bit        found;
      bit        same;
      bit [31:0] key;
      bit [31:0] bkt;
      bit [31:0] sum;
      len = active_words();
      lg = (cfg_tsl < 6) ? 6 : ((cfg_tsl > 10) ? 10 : cfg_tsl);
      found = 1'b0;
      r = '{default: 0};
      if (word_pos < len) begin
         split_buf[word_pos] = it.word;
         hash_acc = mix_word(hash_acc, it.word);
         word_pos++;
      end
      if (!it.last) return 1'b0;
      while (word_pos < len) begin
         split_buf[word_pos] = '0;
         hash_acc = mix_word(hash_acc, 32'd0);
         word_pos++;
      end
      key = close_hash(hash_acc);
      hash_acc = '0;
      word_pos = 0;
      bkt = key & ((32'd1 << lg) - 1);
      e = head_tbl[bkt];
      steps = 0;
      while (!found && e < MAX_ENTRIES && steps < MAX_ENTRIES) begin
         if (key_tbl[e] == key) begin
            same = 1'b1;
            for (int i = 0; i < len; i++)
               if (words_tbl[e * 8 + i] != split_buf[i]) same = 1'b0;
            found = same;
         end
         if (!found) e = link_tbl[e];
         steps++;
      end
      if (found) begin
         sum = weight_tbl[e] + it.sup;
         if (sum < it.sup) sum = 32'hFFFF_FFFF;
         weight_tbl[e] = sum;
         r.status = STATUS_ADDED;
         r.idx = 10'(e);
         r.sup = sum;
      end else if (it.op) begin
         r.status = STATUS_NOT_FOUND;
      end else if (used_count >= MAX_ENTRIES) begin
         r.status = STATUS_FULL;
      end else begin
         e = used_count;
         key_tbl[e] = key;
         for (int i = 0; i < 8; i++) words_tbl[e * 8 + i] = (i < len) ? split_buf[i] : 32'd0;
         weight_tbl[e] = it.sup;
         link_tbl[e] = head_tbl[bkt];
         head_tbl[bkt] = 11'(e);
         used_count++;
         r.status = STATUS_INSERTED;
         r.idx = 10'(e);
         r.sup = it.sup;
      end
      r.total = used_count;
      return 1'b1;
   endfunction

   // Sender: one item per handshake, random gaps while idling is on.
   always @(posedge clock) begin
      lookup_result_type r;
      bit                free;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         free = !req_tvalid;
         if (req_tvalid && req_tready) begin
            free = 1'b1;
            if (predict_lookup(cur_item, r)) expected_lookups.push_back(r);
         end
         if (free) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               if (idle_on && $urandom_range(0, 9) == 0) begin
                  send_gap = $urandom_range(1, 13) - 1;
                  req_tvalid <= 1'b0;
               end else begin
                  cur_item = pending_words.pop_front();
                  req_tvalid <= 1'b1;
                  req_tdata <= {cur_item.bip, cur_item.sup, cur_item.word};
                  req_tuser <= cur_item.op;
                  req_tlast <= cur_item.last;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, and one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_trigger && !hold_done) begin
         hold_count++;
         if (hold_count >= HOLD_CYCLES) hold_done = 1'b1;
         rsp_tready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         recv_gap = $urandom_range(1, 13) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_lookups.size() == 0) begin
            $error("unexpected result item: status %0d", rsp_tuser);
            fail_count++;
         end else begin
            want = expected_lookups.pop_front();
            if (rsp_tuser != want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[9:0] != want.idx) begin
               $error("entry_index: expected %0d, actual %0d", want.idx, rsp_tdata[9:0]);
               fail_count++;
            end
            if (rsp_tdata[41:10] != want.sup) begin
               $error("entry_support: expected %h, actual %h", want.sup, rsp_tdata[41:10]);
               fail_count++;
            end
            if (rsp_tdata[52:42] != want.total) begin
               $error("entry_total: expected %0d, actual %0d", want.total, rsp_tdata[52:42]);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCH_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic push_word(bit op, bit [31:0] word, bit last, bit [31:0] sup, bit [15:0] bip);
      split_item_type it;
      it.op = op;
      it.word = word;
      it.last = last;
      it.sup = sup;
      it.bip = bip;
      pending_words.push_back(it);
   endtask

   task automatic write_reg(bit [7:0] idx, bit [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_TABLE_SIZE_LOG2) cfg_tsl = value[3:0];
      else if (idx == CSR_SPLIT_WORDS) cfg_sw = value[3:0];
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_words.size() > 0 || req_tvalid || expected_lookups.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic gen_split(int reuse_pct);
      bit [31:0] vec[8];
      int        len;
      int        n;
      int        mode;
      bit        op;
      bit [31:0] sup;
      bit [31:0] word;
      len = active_words();
      n = len;
      if (vector_pool.size() > 0 && $urandom_range(0, 99) < reuse_pct) begin
         vec = vector_pool[$urandom_range(0, vector_pool.size() - 1)];
      end else begin
         for (int i = 0; i < 8; i++) begin
            case ($urandom_range(0, 15))
               0: vec[i] = 32'd0;
               1: vec[i] = 32'hFFFF_FFFF;
               default: vec[i] = $urandom;
            endcase
         end
         mode = $urandom_range(0, 9);
         if (mode == 0) begin
            n = $urandom_range(1, len);
            for (int i = n; i < 8; i++) vec[i] = 32'd0;
         end else if (mode == 1) begin
            n = len + $urandom_range(1, 3);
         end
         if (vector_pool.size() < 48) vector_pool.push_back(vec);
      end
      op = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 7))
         0: sup = 32'hFFFF_FFFF;
         1: sup = $urandom_range(0, 255);
         default: sup = $urandom;
      endcase
      for (int i = 0; i < n; i++) begin
         word = (i < len) ? vec[i] : $urandom;
         if (i == n - 1) push_word(op, word, 1'b1, sup, 16'($urandom));
         else push_word(1'($urandom), word, 1'b0, $urandom, 16'($urandom));
      end
   endtask

   task automatic run_phase(bit [3:0] tsl, bit [3:0] sw, int splits, int reuse_pct);
      write_reg(CSR_TABLE_SIZE_LOG2, {28'd0, tsl});
      write_reg(CSR_SPLIT_WORDS, {28'd0, sw});
      vector_pool.delete();
      for (int i = 0; i < splits; i++) gen_split(reuse_pct);
      drain();
   endtask

   initial begin
      for (int i = 0; i < 1024; i++) head_tbl[i] = NIL_LINK;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_reg(CSR_TABLE_SIZE_LOG2, 32'd10);
      write_reg(CSR_SPLIT_WORDS, 32'd1);
      push_word(1'b1, 32'd0, 1'b1, 32'd5, 16'd0);
      push_word(1'b0, 32'd0, 1'b1, 32'hFFFF_0000, 16'd0);
      push_word(1'b0, 32'd0, 1'b1, 32'hFFFF_0000, 16'd1);
      push_word(1'b1, 32'd0, 1'b1, 32'd1, 16'd2);
      push_word(1'b0, 32'hFFFF_FFFF, 1'b1, 32'd0, 16'hFFFF);
      push_word(1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
      drain();
      write_reg(CSR_SPLIT_WORDS, 32'd4);
      push_word(1'b0, 32'd1, 1'b0, 32'd0, 16'd0);
      push_word(1'b0, 32'd2, 1'b1, 32'd7, 16'd3);
      for (int i = 0; i < 6; i++) push_word(1'b0, 32'd10 + i, i == 5, 32'd9, 16'd4);
      push_word(1'b1, 32'd1, 1'b0, 32'd0, 16'd0);
      push_word(1'b1, 32'd2, 1'b0, 32'd0, 16'd0);
      push_word(1'b1, 32'd0, 1'b0, 32'd0, 16'd0);
      push_word(1'b1, 32'd0, 1'b1, 32'd3, 16'd0);
      drain();
      write_reg(CSR_TABLE_SIZE_LOG2, 32'd3);
      write_reg(CSR_SPLIT_WORDS, 32'd0);
      push_word(1'b0, 32'h1234_5678, 1'b1, 32'd1, 16'd5);
      push_word(1'b0, 32'h1234_5678, 1'b1, 32'd1, 16'd5);
      drain();
      write_reg(CSR_TABLE_SIZE_LOG2, 32'd15);
      write_reg(CSR_SPLIT_WORDS, 32'd15);
      for (int i = 0; i < 8; i++) push_word(1'b0, 32'hA5A5_0000 + i, i == 7, 32'd2, 16'd6);
      drain();

      run_phase(4'd6, 4'd3, 70, 35);
      run_phase(4'd10, 4'd8, 40, 35);
      hold_trigger = 1'b1;
      run_phase(4'd7, 4'd1, 650, 10);
      run_phase(4'd9, 4'd2, 250, 20);
      idle_on = 1'b0;
      run_phase(4'd8, 4'd1, 120, 40);

      if (fail_count == 0 && expected_lookups.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
`default_nettype wire
